[rtl/rmad_pkg.sv]
// Package for the running median absolute deviation core.
// Holds sizes, word types, heap entry type and the sequencer state enum.
package rmad_pkg;

   localparam int MaxItems = 1024;
   localparam int HalfCap = (MaxItems + 1) / 2;
   localparam int AddrW = (HalfCap > 1) ? $clog2(HalfCap) : 1;
   localparam int CntW = $clog2(MaxItems + 1);
   localparam int EntW = 44;
   localparam int SumW = 54;
   localparam int CostW = 30;
   localparam logic [SumW-1:0] CostMod = SumW'(64'd1000000007);
   // 2^30 mod 1000000007, used to fold the bits from bit 30 upward back down
   localparam int FoldShift = 30;
   localparam logic [26:0] CostFold = 27'd73741817;

   typedef struct packed {
      logic signed [31:0] value;
      logic start_req;
   } req_word_type;

   typedef struct packed {
      logic [CostW-1:0] cost;
      logic overflow;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TOP_RD,
      ST_TOP_WT,
      ST_DEC,
      ST_SD_RD,
      ST_SD_WT,
      ST_SD_CMP,
      ST_SU_RD,
      ST_SU_WT,
      ST_MED_RD,
      ST_MED_WT,
      ST_MOD,
      ST_OUT
   } state_type;

endpackage

[rtl/running_median_abs_deviation_core.sv]
// Top level of the running median absolute deviation core.
// Uses rmad_pkg and two rmad_heap_ram instances (lower max-heap, upper min-heap).
//
//   channel | ports              | word
//   input   | req_valid/stall    | rmad_pkg::req_word_type
//   result  | rsp_valid/stall    | rmad_pkg::rsp_word_type
//
// One word at a time. After the accept cycle an item reads both tops, runs
// the sift-down walk when a top is displaced, then the sift-up walk, reads
// the median, folds the result modulo 1000000007 and loads the output
// register.
// Synchronous active-high reset clears count, sums, the sequencer and rsp_valid.
// The result is held in an output register; the next word is taken once
// that register is emptied or being taken.
module running_median_abs_deviation_core (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  rmad_pkg::req_word_type req_word,
   output logic rsp_valid,
   input  logic rsp_stall,
   output rmad_pkg::rsp_word_type rsp_word
);
   localparam int AW = rmad_pkg::AddrW;
   localparam int EW = rmad_pkg::EntW;
   localparam int SW = rmad_pkg::SumW;
   localparam int CW = rmad_pkg::CntW;
   localparam int PW = SW - rmad_pkg::FoldShift + $bits(rmad_pkg::CostFold);

   rmad_pkg::state_type state_ff, state_in;

   logic [CW-1:0] count_ff, count_in;
   logic signed [SW-1:0] lsum_ff, lsum_in, usum_ff, usum_in;
   logic signed [EW-1:0] a_ff, a_in;       // new adjusted value
   logic signed [EW-1:0] mv_ff, mv_in;     // value to insert by sift-up
   logic signed [EW-1:0] lc_ff, lc_in;     // left child during sift-down
   logic sdu_ff, sdu_in;                   // sift-down heap: 1 = upper
   logic suu_ff, suu_in;                   // sift-up heap: 1 = upper
   logic [CW-1:0] k_ff, k_in;              // walk position
   logic [CW-1:0] sz_ff, sz_in;            // sift-down heap size
   logic [SW-1:0] rem_ff, rem_in;
   logic rv_ff, rv_in;
   rmad_pkg::rsp_word_type ro_ff, ro_in;

   logic l_we, u_we;
   logic [AW-1:0] l_wa, u_wa, l_ra, u_ra;
   logic signed [EW-1:0] l_wd, u_wd, l_rd, u_rd;

   rmad_heap_ram lower_ram (.clock, .we(l_we), .waddr(l_wa), .wdata(l_wd),
      .raddr(l_ra), .rdata(l_rd));
   rmad_heap_ram upper_ram (.clock, .we(u_we), .waddr(u_wa), .wdata(u_wd),
      .raddr(u_ra), .rdata(u_rd));

   logic take;
   logic [CW-1:0] n0;
   logic signed [EW-1:0] sd_rd, su_rd;
   logic [CW-1:0] lidx, ridx, par;
   logic sd_better, su_better, r_better;
   logic signed [SW-1:0] diff;
   logic [PW-1:0] fold_prod;
   logic [SW-1:0] fold;

   assign req_stall = (state_ff != rmad_pkg::ST_IDLE) || (rv_ff && rsp_stall);
   assign take = req_valid && !req_stall;
   assign rsp_valid = rv_ff;
   assign rsp_word = ro_ff;
   assign n0 = req_word.start_req ? '0 : count_ff;
   assign sd_rd = sdu_ff ? u_rd : l_rd;
   assign su_rd = suu_ff ? u_rd : l_rd;
   assign lidx = CW'({k_ff, 1'b1});
   assign ridx = lidx + CW'(1);
   assign par = (k_ff - CW'(1)) >> 1;
   assign diff = usum_ff - lsum_ff;
   // fold the bits from bit 30 upward back in as multiples of 2^30 mod the modulus
   assign fold_prod = PW'(rem_ff[SW-1:rmad_pkg::FoldShift]) * PW'(rmad_pkg::CostFold);
   assign fold = SW'(fold_prod) + SW'(rem_ff[rmad_pkg::FoldShift-1:0]);
   // sift-down: right child (in sd_rd) beats left child (lc_ff)?
   assign r_better = sdu_ff ? (sd_rd < lc_ff) : (sd_rd > lc_ff);
   // does left child beat moving value a_ff
   assign sd_better = sdu_ff ? (lc_ff < a_ff) : (lc_ff > a_ff);
   // sift-up: does mv beat parent
   assign su_better = suu_ff ? (mv_ff < su_rd) : (mv_ff > su_rd);

   // Advance registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rmad_pkg::ST_IDLE;
         count_ff <= '0;
         lsum_ff <= '0;
         usum_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         lsum_ff <= lsum_in;
         usum_ff <= usum_in;
         rv_ff <= rv_in;
      end
      a_ff <= a_in; mv_ff <= mv_in; lc_ff <= lc_in; sdu_ff <= sdu_in;
      suu_ff <= suu_in; k_ff <= k_in; sz_ff <= sz_in; rem_ff <= rem_in;
      ro_ff <= ro_in;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rmad_pkg::ST_IDLE: begin
            if (take) begin
               if (!req_word.start_req && count_ff == CW'(rmad_pkg::MaxItems))
                  state_in = rmad_pkg::ST_IDLE;
               else if (n0 == '0) state_in = rmad_pkg::ST_SU_RD;
               else state_in = rmad_pkg::ST_TOP_RD;
            end
         end
         rmad_pkg::ST_TOP_RD: state_in = rmad_pkg::ST_TOP_WT;
         rmad_pkg::ST_TOP_WT: state_in = rmad_pkg::ST_DEC;
         rmad_pkg::ST_DEC: begin
            if ((count_ff[0] && a_ff > u_rd) || (!count_ff[0] && a_ff < l_rd))
               state_in = rmad_pkg::ST_SD_RD;
            else state_in = rmad_pkg::ST_SU_RD;
         end
         rmad_pkg::ST_SD_RD: begin
            if (lidx >= sz_ff || k_ff >= CW'(rmad_pkg::HalfCap))
               state_in = rmad_pkg::ST_SU_RD;
            else state_in = rmad_pkg::ST_SD_WT;
         end
         rmad_pkg::ST_SD_WT: state_in = rmad_pkg::ST_SD_CMP;
         rmad_pkg::ST_SD_CMP: begin
            if (sd_better || (ridx < sz_ff && (r_better ? (sdu_ff ? sd_rd < a_ff
                : sd_rd > a_ff) : 1'b0)))
               state_in = rmad_pkg::ST_SD_RD;
            else state_in = rmad_pkg::ST_SU_RD;
         end
         rmad_pkg::ST_SU_RD: begin
            if (k_ff == '0) state_in = rmad_pkg::ST_MED_RD;
            else state_in = rmad_pkg::ST_SU_WT;
         end
         rmad_pkg::ST_SU_WT: begin
            if (su_better) state_in = rmad_pkg::ST_SU_RD;
            else state_in = rmad_pkg::ST_MED_RD;
         end
         rmad_pkg::ST_MED_RD: state_in = rmad_pkg::ST_MED_WT;
         rmad_pkg::ST_MED_WT: state_in = rmad_pkg::ST_MOD;
         rmad_pkg::ST_MOD: begin
            if (rem_ff[SW-1:rmad_pkg::FoldShift] == '0) state_in = rmad_pkg::ST_OUT;
         end
         rmad_pkg::ST_OUT: state_in = rmad_pkg::ST_IDLE;
         default: state_in = rmad_pkg::ST_IDLE;
      endcase
   end

   // Datapath and memory control
   always_comb begin
      count_in = count_ff; lsum_in = lsum_ff; usum_in = usum_ff;
      a_in = a_ff; mv_in = mv_ff; lc_in = lc_ff; sdu_in = sdu_ff;
      suu_in = suu_ff; k_in = k_ff; sz_in = sz_ff; rem_in = rem_ff;
      ro_in = ro_ff;
      rv_in = rv_ff && rsp_stall;
      l_we = 1'b0; u_we = 1'b0;
      l_wa = '0; u_wa = '0; l_wd = a_ff; u_wd = a_ff; l_ra = '0; u_ra = '0;
      unique case (state_ff)
         rmad_pkg::ST_IDLE: begin
            if (take) begin
               if (!req_word.start_req && count_ff == CW'(rmad_pkg::MaxItems)) begin
                  ro_in.cost = '0; ro_in.overflow = 1'b1; rv_in = 1'b1;
               end else begin
                  if (req_word.start_req) begin
                     lsum_in = '0; usum_in = '0;
                  end
                  // first item of a sequence seeds the upper sum
                  if (n0 == '0) usum_in = SW'(req_word.value);
                  count_in = n0;
                  a_in = EW'(req_word.value) - EW'(signed'({1'b0, n0}));
                  mv_in = EW'(req_word.value) - EW'(signed'({1'b0, n0}));
                  suu_in = 1'b1;
                  k_in = '0;
               end
            end
         end
         rmad_pkg::ST_TOP_RD: begin
            l_ra = '0; u_ra = '0;
         end
         rmad_pkg::ST_TOP_WT: ;
         rmad_pkg::ST_DEC: begin
            // count odd: compare with upper top; even: with lower top
            if (count_ff[0]) begin
               if (a_ff > u_rd) begin
                  sdu_in = 1'b1; mv_in = u_rd; suu_in = 1'b0;
                  sz_in = count_ff - (count_ff >> 1);
                  k_in = '0;
                  usum_in = usum_ff + SW'(a_ff) - SW'(u_rd);
                  lsum_in = lsum_ff + SW'(u_rd);
               end else begin
                  mv_in = a_ff; suu_in = 1'b0; k_in = count_ff >> 1;
                  lsum_in = lsum_ff + SW'(a_ff);
               end
            end else begin
               if (a_ff >= l_rd) begin
                  mv_in = a_ff; suu_in = 1'b1; k_in = count_ff >> 1;
                  usum_in = usum_ff + SW'(a_ff);
               end else begin
                  sdu_in = 1'b0; mv_in = l_rd; suu_in = 1'b1;
                  sz_in = count_ff >> 1;
                  k_in = '0;
                  lsum_in = lsum_ff + SW'(a_ff) - SW'(l_rd);
                  usum_in = usum_ff + SW'(l_rd);
               end
            end
         end
         rmad_pkg::ST_SD_RD: begin
            l_ra = AW'(lidx); u_ra = AW'(lidx);
            if (lidx >= sz_ff || k_ff >= CW'(rmad_pkg::HalfCap)) begin
               // place moving value at k, then sift-up of moved value
               if (sdu_ff) begin u_we = 1'b1; u_wa = AW'(k_ff); u_wd = a_ff; end
               else begin l_we = 1'b1; l_wa = AW'(k_ff); l_wd = a_ff; end
               k_in = suu_ff ? (count_ff - (count_ff >> 1)) : (count_ff >> 1);
            end
         end
         rmad_pkg::ST_SD_WT: begin
            lc_in = sd_rd;
            l_ra = AW'(ridx); u_ra = AW'(ridx);
         end
         rmad_pkg::ST_SD_CMP: begin
            if (ridx < sz_ff && r_better && (sdu_ff ? sd_rd < a_ff : sd_rd > a_ff)) begin
               if (sdu_ff) begin u_we = 1'b1; u_wa = AW'(k_ff); u_wd = sd_rd; end
               else begin l_we = 1'b1; l_wa = AW'(k_ff); l_wd = sd_rd; end
               k_in = ridx;
            end else if (sd_better && !(ridx < sz_ff && r_better)) begin
               if (sdu_ff) begin u_we = 1'b1; u_wa = AW'(k_ff); u_wd = lc_ff; end
               else begin l_we = 1'b1; l_wa = AW'(k_ff); l_wd = lc_ff; end
               k_in = lidx;
            end else begin
               if (sdu_ff) begin u_we = 1'b1; u_wa = AW'(k_ff); u_wd = a_ff; end
               else begin l_we = 1'b1; l_wa = AW'(k_ff); l_wd = a_ff; end
               k_in = suu_ff ? (count_ff - (count_ff >> 1)) : (count_ff >> 1);
            end
         end
         rmad_pkg::ST_SU_RD: begin
            l_ra = AW'(par); u_ra = AW'(par);
            if (k_ff == '0 || k_ff >= CW'(rmad_pkg::HalfCap)) begin
               if (k_ff < CW'(rmad_pkg::HalfCap)) begin
                  if (suu_ff) begin u_we = 1'b1; u_wa = AW'(k_ff); u_wd = mv_ff; end
                  else begin l_we = 1'b1; l_wa = AW'(k_ff); l_wd = mv_ff; end
               end
               count_in = count_ff + CW'(1);
            end
         end
         rmad_pkg::ST_SU_WT: begin
            if (su_better) begin
               if (suu_ff) begin u_we = 1'b1; u_wa = AW'(k_ff); u_wd = su_rd; end
               else begin l_we = 1'b1; l_wa = AW'(k_ff); l_wd = su_rd; end
               k_in = par;
            end else begin
               if (suu_ff) begin u_we = 1'b1; u_wa = AW'(k_ff); u_wd = mv_ff; end
               else begin l_we = 1'b1; l_wa = AW'(k_ff); l_wd = mv_ff; end
               count_in = count_ff + CW'(1);
            end
         end
         rmad_pkg::ST_MED_RD: u_ra = '0;
         rmad_pkg::ST_MED_WT: begin
            // subtract median when count odd, clamp at zero
            if (count_ff[0]) begin
               if (diff - SW'(u_rd) < 0) rem_in = '0;
               else rem_in = SW'(diff - SW'(u_rd));
            end else begin
               if (diff < 0) rem_in = '0;
               else rem_in = SW'(diff);
            end
         end
         rmad_pkg::ST_MOD: begin
            // fold high bits until below 2^30, then one conditional subtract
            if (rem_ff[SW-1:rmad_pkg::FoldShift] != '0) rem_in = fold;
            else if (rem_ff >= rmad_pkg::CostMod) rem_in = rem_ff - rmad_pkg::CostMod;
         end
         rmad_pkg::ST_OUT: begin
            ro_in.cost = rem_ff[rmad_pkg::CostW-1:0];
            ro_in.overflow = 1'b0;
            rv_in = 1'b1;
         end
         default: ;
      endcase
   end
endmodule

[rtl/rmad_heap_ram.sv]
// Heap storage for one heap with one write port and one read port, registered read data.
// Depends on rmad_pkg for entry and address widths.
module rmad_heap_ram (
   input  logic clock,
   input  logic we,
   input  logic [rmad_pkg::AddrW-1:0] waddr,
   input  logic signed [rmad_pkg::EntW-1:0] wdata,
   input  logic [rmad_pkg::AddrW-1:0] raddr,
   output logic signed [rmad_pkg::EntW-1:0] rdata
);
   logic signed [rmad_pkg::EntW-1:0] mem [rmad_pkg::HalfCap];

   // Registered read; reading the address being written returns the old data
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule
